// File: rtl/process_table_scheduler_select_core_defines.svh
// Assertion macros shared by the scheduler checker.
`ifndef PROCESS_TABLE_SCHEDULER_SELECT_CORE_DEFINES_SVH
`define PROCESS_TABLE_SCHEDULER_SELECT_CORE_DEFINES_SVH

// Checked only while out of reset.
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pts_pkg.sv
// Shared types and constants of the task slot scheduler.
`timescale 1ns / 1ps

package pts_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_AW   = $clog2(NUM_SLOTS);
    localparam int SLOT_CW   = $clog2(NUM_SLOTS + 1);
    localparam logic [31:0] NUM_SLOTS_W = 32'(NUM_SLOTS);

    localparam logic       OP_WRITE     = 1'b0;
    localparam logic       OP_SELECT    = 1'b1;
    localparam logic       STRAT_OLDEST = 1'b0;
    localparam logic       STRAT_RATIO  = 1'b1;

    localparam logic [2:0]  ST_UNUSED      = 3'd0;
    localparam logic [2:0]  ST_RUNNABLE    = 3'd3;
    localparam logic [2:0]  ST_RUNNING     = 3'd4;
    localparam logic [1:0]  PRIO_RESET     = 2'd1;
    localparam logic [15:0] WAIT_MAX       = 16'hFFFF;
    localparam logic [31:0] ZERO_DIV_SCORE = 32'd99999999;

    typedef struct packed {
        logic        op;
        logic [5:0]  slot;
        logic [2:0]  new_state;
        logic [1:0]  new_priority;
        logic [31:0] new_create_time;
        logic [31:0] new_run_time;
        logic        clear_wait;
        logic        strategy;
        logic [1:0]  wanted_priority;
        logic [31:0] now_ticks;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [5:0] chosen_slot;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic write_slot;
        logic rd;
        logic oscan;
        logic load_nd;
        logic load_prod;
        logic cmp_ratio;
        logic fin;
        logic load_rsp;
    } pts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic more;
        logic p_match;
    } pts_sts_t;

endpackage

// File: rtl/process_table_scheduler_select_core.sv
// Top level of the task slot scheduler: controller plus table datapath.
`timescale 1ns / 1ps
// Write word: slot written in S_WRITE, result loaded in S_DONE, then next word taken.
// Oldest-waiting select: a single pass over all slots, one table read-modify-write
//   per cycle through the single wait-count write port.
// Ratio select: non-matching slots are skipped; each matching slot passes through
//   S_RND, S_RMUL and S_RCMP in the multiply-then-compare loop against the running best.
// Reset: control and per-slot valid bits clear at once; slots read as unused, priority 1.

module process_table_scheduler_select_core
    import pts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // One word is worked on at a time. The result word sits in an output
    // register, so the next request is taken while that result waits.
    //
    // Oldest-waiting scan is a single pass: slot k is read while slot k-1
    // is scored and its wait count bumped. The bumps do not affect who wins
    // (winner is picked on pre-bump values), so the winner's reset to zero
    // and its promotion to running happen together in the closing S_FIN state.
    //
    // Ratio scan compares run/age fractions exactly by cross products:
    // n * best_d < best_n * d, with a zero age scoring a large constant.
    // Non-matching slots are skipped without the multiply and compare steps.

    pts_cmd_t cmd;
    pts_sts_t sts;

    pts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_op       (req.op),
        .req_strategy (req.strategy),
        .req_stall    (req_stall),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    pts_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

// File: rtl/pts_ctrl.sv
// Sequencing state machine of the task slot scheduler.
`timescale 1ns / 1ps

module pts_ctrl
    import pts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_op,
    input  logic     req_strategy,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output pts_cmd_t cmd,
    input  pts_sts_t sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRITE = 4'd1;
    localparam logic [3:0] S_OSCAN = 4'd2;
    localparam logic [3:0] S_RRD   = 4'd3;
    localparam logic [3:0] S_RND   = 4'd4;
    localparam logic [3:0] S_RMUL  = 4'd5;
    localparam logic [3:0] S_RCMP  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_vld_reg;
    logic       out_vld_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    if (req_op == OP_WRITE)
                        state_next = S_WRITE;
                    else if (req_strategy == STRAT_OLDEST)
                        state_next = S_OSCAN;
                    else
                        state_next = S_RRD;
                end
            end
            S_WRITE:
            begin
                cmd.write_slot = 1'b1;
                state_next     = S_DONE;
            end
            S_OSCAN:
            begin
                // read slot k while slot k-1 is scored and written back
                cmd.oscan = 1'b1;
                cmd.rd    = sts.more;
                if (!sts.more)
                    state_next = S_FIN;
            end
            S_RRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_RND;
            end
            S_RND:
            begin
                if (sts.p_match)
                begin
                    cmd.load_nd = 1'b1;
                    state_next  = S_RMUL;
                end
                else if (sts.more)
                    cmd.rd = 1'b1;
                else
                    state_next = S_FIN;
            end
            S_RMUL:
            begin
                cmd.load_prod = 1'b1;
                state_next    = S_RCMP;
            end
            S_RCMP:
            begin
                cmd.cmp_ratio = 1'b1;
                if (sts.more)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_RND;
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_vld_reg || !rsp_stall)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.load_rsp)
            out_vld_next = 1'b1;
        else if (out_vld_reg && !rsp_stall)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_vld_reg;

endmodule

// File: rtl/pts_datapath.sv
// Slot table memories, scan pipeline and winner tracking.
`timescale 1ns / 1ps

module pts_datapath
    import pts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req,
    input  pts_cmd_t cmd,
    output pts_sts_t sts,
    output rsp_t     rsp
);

    logic [2:0]  state_mem [NUM_SLOTS];
    logic [1:0]  prio_mem  [NUM_SLOTS];
    logic [31:0] ctime_mem [NUM_SLOTS];
    logic [31:0] rtime_mem [NUM_SLOTS];
    logic [15:0] wait_mem  [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] info_vld_reg;
    logic [NUM_SLOTS-1:0] info_vld_next;
    logic [NUM_SLOTS-1:0] wait_vld_reg;
    logic [NUM_SLOTS-1:0] wait_vld_next;

    req_t               req_reg;
    logic [SLOT_CW-1:0] idx_reg;
    logic [SLOT_CW-1:0] idx_next;
    logic               p_vld_reg;
    logic [SLOT_AW-1:0] p_idx_reg;
    logic               have_reg;
    logic               have_next;
    logic [SLOT_AW-1:0] best_reg;
    logic [15:0]        best_wait_reg;
    logic [31:0]        bn_reg;
    logic [31:0]        bd_reg;
    logic [31:0]        n_reg;
    logic [31:0]        d_reg;
    logic [SLOT_AW-1:0] cand_reg;
    logic [63:0]        lhs_reg;
    logic [63:0]        rhs_reg;
    rsp_t               rsp_reg;

    // registered read data
    logic [2:0]  state_rd_reg;
    logic [1:0]  prio_rd_reg;
    logic [31:0] ctime_rd_reg;
    logic [31:0] rtime_rd_reg;
    logic [15:0] wait_rd_reg;
    logic        info_vrd_reg;
    logic        wait_vrd_reg;

    logic [SLOT_AW-1:0] rd_addr;
    logic [SLOT_AW-1:0] wr_addr;
    logic               in_range;
    logic [2:0]         eff_state;
    logic [1:0]         eff_prio;
    logic [31:0]        eff_ctime;
    logic [31:0]        eff_rtime;
    logic [15:0]        eff_wait;
    logic               p_match;
    logic [31:0]        diff;
    logic               info_we;
    logic               state_we;
    logic [SLOT_AW-1:0] state_wa;
    logic [2:0]         state_wd;
    logic               wait_we;
    logic [SLOT_AW-1:0] wait_wa;
    logic [15:0]        wait_wd;
    logic               take_oldest;
    logic               take_ratio;

    assign rd_addr  = idx_reg[SLOT_AW-1:0];
    assign wr_addr  = SLOT_AW'(req_reg.slot);
    assign in_range = (32'(req_reg.slot) < NUM_SLOTS_W);

    // entries never written read back as their reset values
    assign eff_state = info_vrd_reg ? state_rd_reg : ST_UNUSED;
    assign eff_prio  = info_vrd_reg ? prio_rd_reg  : PRIO_RESET;
    assign eff_ctime = info_vrd_reg ? ctime_rd_reg : 32'd0;
    assign eff_rtime = info_vrd_reg ? rtime_rd_reg : 32'd0;
    assign eff_wait  = wait_vrd_reg ? wait_rd_reg  : 16'd0;

    assign p_match = (eff_state == ST_RUNNABLE) && (eff_prio == req_reg.wanted_priority);
    assign diff    = req_reg.now_ticks - eff_ctime;

    assign sts.more    = (idx_reg != SLOT_CW'(NUM_SLOTS));
    assign sts.p_match = p_match;

    assign take_oldest = cmd.oscan && p_vld_reg && p_match
                         && (!have_reg || (best_wait_reg < eff_wait));
    assign take_ratio  = cmd.cmp_ratio && (!have_reg || (lhs_reg < rhs_reg));

    // write ports
    assign info_we = cmd.write_slot && in_range;

    always_comb
    begin
        state_we = 1'b0;
        state_wa = wr_addr;
        state_wd = req_reg.new_state;
        if (cmd.write_slot)
            state_we = in_range;
        else if (cmd.fin)
        begin
            state_we = have_reg;
            state_wa = best_reg;
            state_wd = ST_RUNNING;
        end
    end

    always_comb
    begin
        wait_we = 1'b0;
        wait_wa = p_idx_reg;
        wait_wd = 16'd0;
        if (cmd.write_slot)
        begin
            wait_we = in_range && req_reg.clear_wait;
            wait_wa = wr_addr;
        end
        else if (cmd.oscan)
        begin
            // saturating age bump of every matching slot
            wait_we = p_vld_reg && p_match;
            wait_wd = (eff_wait == WAIT_MAX) ? eff_wait : eff_wait + 16'd1;
        end
        else if (cmd.fin)
        begin
            wait_we = have_reg && (req_reg.strategy == STRAT_OLDEST);
            wait_wa = best_reg;
        end
    end

    always_comb
    begin
        info_vld_next = info_vld_reg;
        wait_vld_next = wait_vld_reg;
        if (info_we)
            info_vld_next[wr_addr] = 1'b1;
        if (wait_we)
            wait_vld_next[wait_wa] = 1'b1;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.capture)
            idx_next = '0;
        else if (cmd.rd)
            idx_next = idx_reg + SLOT_CW'(1);
    end

    always_comb
    begin
        have_next = have_reg;
        if (cmd.capture)
            have_next = 1'b0;
        else if ((cmd.oscan && p_vld_reg && p_match) || cmd.cmp_ratio)
            have_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_vld_reg <= '0;
            wait_vld_reg <= '0;
            idx_reg      <= '0;
            p_vld_reg    <= 1'b0;
            have_reg     <= 1'b0;
        end
        else
        begin
            info_vld_reg <= info_vld_next;
            wait_vld_reg <= wait_vld_next;
            idx_reg      <= idx_next;
            p_vld_reg    <= cmd.rd;
            have_reg     <= have_next;
        end
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (state_we)
            state_mem[state_wa] <= state_wd;
        if (info_we)
        begin
            prio_mem[wr_addr]  <= req_reg.new_priority;
            ctime_mem[wr_addr] <= req_reg.new_create_time;
            rtime_mem[wr_addr] <= req_reg.new_run_time;
        end
        if (wait_we)
            wait_mem[wait_wa] <= wait_wd;
        if (cmd.rd)
        begin
            state_rd_reg <= state_mem[rd_addr];
            prio_rd_reg  <= prio_mem[rd_addr];
            ctime_rd_reg <= ctime_mem[rd_addr];
            rtime_rd_reg <= rtime_mem[rd_addr];
            wait_rd_reg  <= wait_mem[rd_addr];
            info_vrd_reg <= info_vld_reg[rd_addr];
            wait_vrd_reg <= wait_vld_reg[rd_addr];
            p_idx_reg    <= rd_addr;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
            bn_reg  <= 32'd0;
            bd_reg  <= 32'd1;
        end
        if (take_oldest)
        begin
            best_reg      <= p_idx_reg;
            best_wait_reg <= eff_wait;
        end
        if (cmd.load_nd)
        begin
            n_reg    <= (diff == 32'd0) ? ZERO_DIV_SCORE : eff_rtime;
            d_reg    <= (diff == 32'd0) ? 32'd1 : diff;
            cand_reg <= p_idx_reg;
        end
        if (cmd.load_prod)
        begin
            lhs_reg <= 64'(n_reg) * 64'(bd_reg);
            rhs_reg <= 64'(bn_reg) * 64'(d_reg);
        end
        if (take_ratio)
        begin
            best_reg <= cand_reg;
            bn_reg   <= n_reg;
            bd_reg   <= d_reg;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.found       <= have_reg;
            rsp_reg.chosen_slot <= have_reg ? 6'(best_reg) : 6'd0;
        end
    end

    assign rsp = rsp_reg;

endmodule

// File: rtl/pts_checker.sv
// Port-level checks of the task slot scheduler and their bind.
`timescale 1ns / 1ps
`include "process_table_scheduler_select_core_defines.svh"

module pts_checker
    import pts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    `PTS_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "result word changed while stalled")
    `PTS_ASSERT(a_one_at_a_time, clk, rst_n, req_valid && !req_stall |=> req_stall, "request taken while busy")
    `PTS_ASSERT(a_no_instant_rsp, clk, rst_n, req_valid && !req_stall |=> !$rose(rsp_valid), "result appeared right after accept")
    `PTS_ASSERT(a_none_is_zero, clk, rst_n, rsp_valid && !rsp.found |-> rsp.chosen_slot == 6'd0, "miss result with nonzero slot")
    `PTS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !rsp_valid, "result valid during reset")

endmodule

bind process_table_scheduler_select_core pts_checker u_pts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
